// ===== hdl/two_pkg.sv =====
`default_nettype none

package two_pkg;

  // field and register widths
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned POS_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_OFFSET = 2'd2;

  localparam logic [31:0]        WHEEL_SCALE_RST = 32'd409949;
  localparam logic signed [31:0] BACK_OFFSET_RST = 32'sd21738;
  localparam logic signed [31:0] SIDE_OFFSET_RST = 32'sd104006;

  // serial multiplier: radix-4 digits, signed operands
  localparam int unsigned MUL_W     = 36;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned MUL_STEPS = MUL_W / 2;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  // CORDIC, binary angle with one turn = 2^32
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned COR_W        = 34;
  localparam int unsigned COR_IDX_W    = 5;
  localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // restoring divider
  localparam int unsigned NUM_W     = 51;
  localparam int unsigned DEN_W     = 33;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  // fixed-point constants
  localparam logic signed [MUL_W-1:0] INV_TWO_PI_C = 36'sd683565276;
  localparam logic signed [MUL_W-1:0] DEG_TO_RAD_C = 36'sd74961321;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] back_wheel_angle;
    logic signed [ANGLE_W-1:0] side_wheel_angle;
    logic signed [ANGLE_W-1:0] gyro_rotation;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] turns;
  } cor_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [COR_W-1:0] c;
    logic signed [COR_W-1:0] s;
  } cor_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [31:0] atan_turns(input logic [COR_IDX_W-1:0] i);
    case (i)
      5'd0:  return 32'd536870912;
      5'd1:  return 32'd316933406;
      5'd2:  return 32'd167458907;
      5'd3:  return 32'd85004756;
      5'd4:  return 32'd42667331;
      5'd5:  return 32'd21354465;
      5'd6:  return 32'd10679838;
      5'd7:  return 32'd5340245;
      5'd8:  return 32'd2670163;
      5'd9:  return 32'd1335087;
      5'd10: return 32'd667544;
      5'd11: return 32'd333772;
      5'd12: return 32'd166886;
      5'd13: return 32'd83443;
      5'd14: return 32'd41722;
      5'd15: return 32'd20861;
      5'd16: return 32'd10430;
      5'd17: return 32'd5215;
      5'd18: return 32'd2608;
      5'd19: return 32'd1304;
      5'd20: return 32'd652;
      5'd21: return 32'd326;
      5'd22: return 32'd163;
      5'd23: return 32'd81;
      5'd24: return 32'd41;
      5'd25: return 32'd20;
      5'd26: return 32'd10;
      5'd27: return 32'd5;
      5'd28: return 32'd3;
      5'd29: return 32'd1;
      5'd30: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/two_mul.sv =====
`default_nettype none

module two_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  two_pkg::mul_req_t  req_i,
  output two_pkg::mul_rsp_t  rsp_o
);
  import two_pkg::*;

  logic                     busy_q, fin_q, done_q, neg_q;
  logic [MUL_CNT_W-1:0]     cnt_q;
  logic [MUL_W-1:0]         mb_q;
  logic [PROD_W-1:0]        m1_q, m3_q, acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [MUL_W-1:0]         ma, mb;
  logic [PROD_W-1:0]        addend;
  logic                     last;

  // operand magnitudes, sign applied at the end
  assign ma = req_i.a[MUL_W-1] ? ({MUL_W{1'b0}} - unsigned'(req_i.a)) : unsigned'(req_i.a);
  assign mb = req_i.b[MUL_W-1] ? ({MUL_W{1'b0}} - unsigned'(req_i.b)) : unsigned'(req_i.b);
  assign last = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));

  // one radix-4 digit of the multiplier per cycle
  always_comb begin
    case (mb_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = m1_q;
      2'd2:    addend = m1_q << 1;
      default: addend = m3_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      m1_q  <= PROD_W'(ma);
      m3_q  <= PROD_W'(ma) + (PROD_W'(ma) << 1);
      mb_q  <= mb;
      acc_q <= '0;
      neg_q <= req_i.a[MUL_W-1] ^ req_i.b[MUL_W-1];
      cnt_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
      m1_q  <= m1_q << 2;
      m3_q  <= m3_q << 2;
      mb_q  <= mb_q >> 2;
      cnt_q <= cnt_q + 1'b1;
    end
    if (fin_q) begin
      prod_q <= neg_q ? ({PROD_W{1'b0}} - acc_q) : acc_q;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

`default_nettype wire

// ===== hdl/two_cordic.sv =====
`default_nettype none

module two_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  two_pkg::cor_req_t  req_i,
  output two_pkg::cor_rsp_t  rsp_o
);
  import two_pkg::*;

  logic                    busy_q, fin_q, done_q, flip_q;
  logic [COR_IDX_W-1:0]    i_q;
  logic signed [COR_W-1:0] x_q, y_q, z_q, c_q, s_q;
  logic signed [COR_W-1:0] xs, ys, at;
  logic [31:0]             t_q1, t_rot;
  logic                    flip, last;

  // fold the angle into the right half-plane
  assign t_q1  = req_i.turns + 32'h4000_0000;
  assign flip  = t_q1[31];
  assign t_rot = flip ? (req_i.turns + 32'h8000_0000) : req_i.turns;

  assign xs   = x_q >>> i_q;
  assign ys   = y_q >>> i_q;
  assign at   = COR_W'(atan_turns(i_q));
  assign last = (i_q == COR_IDX_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one rotation step per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= COR_W'(signed'(t_rot));
      flip_q <= flip;
      i_q    <= '0;
    end else if (busy_q) begin
      if (!z_q[COR_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
      i_q <= i_q + 1'b1;
    end
    if (fin_q) begin
      c_q <= flip_q ? -x_q : x_q;
      s_q <= flip_q ? -y_q : y_q;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.c    = c_q;
  assign rsp_o.s    = s_q;

endmodule

`default_nettype wire

// ===== hdl/two_div.sv =====
`default_nettype none

module two_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  two_pkg::div_req_t  req_i,
  output two_pkg::div_rsp_t  rsp_o
);
  import two_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic [NUM_W-1:0]     quo_q;
  logic [DEN_W:0]       trial, diff;
  logic                 ge, last;

  // restoring step: one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign last  = (cnt_q == DIV_CNT_W'(NUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/tracking_wheel_odometry.sv =====
// Work per item: when the heading changed, thirteen serial multiplies on one shared
//   radix-4 multiplier, two CORDIC passes and a divide; when it is unchanged, fewer
//   multiplies, one CORDIC pass and no divide; one sequencer runs them in turn.
// Throughput: a new item is taken only in idle, once the previous one is finished;
//   it may be taken while the previous result waits in the output register.
// Reset: asynchronous, active low; position, previous readings, configuration registers and control reset at once.
`default_nettype none

module tracking_wheel_odometry (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  two_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output two_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [two_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import two_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_BACK = 19'h00002,
    S_SIDE = 19'h00004,
    S_HEAD = 19'h00008,
    S_CALC = 19'h00010,
    S_TDT  = 19'h00020,
    S_CORD = 19'h00040,
    S_DIV  = 19'h00080,
    S_RX   = 19'h00100,
    S_OX   = 19'h00200,
    S_RY   = 19'h00400,
    S_OY   = 19'h00800,
    S_TL   = 19'h01000,
    S_CORL = 19'h02000,
    S_P1   = 19'h04000,
    S_P2   = 19'h08000,
    S_P3   = 19'h10000,
    S_P4   = 19'h20000,
    S_FIN  = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  in_item_t                 in_q;
  out_item_t                out_q;
  logic                     out_valid_q;
  logic [31:0]              ws_q;
  logic signed [31:0]       bo_q, so_q;
  logic signed [31:0]       back_q, side_q, head_q;
  logic signed [31:0]       last_back_q, last_side_q, last_head_q;
  logic signed [31:0]       mx_q, my_q, dx_q, dy_q;
  logic signed [32:0]       dt_q, ratio_q;
  logic [31:0]              turns_q;
  logic signed [COR_W-1:0]  pc_q, ps_q;
  logic signed [41:0]       r1_q, nx_q, ny_q;
  logic signed [PROD_W-1:0] p1_q;
  logic signed [POS_W-1:0]  acc_x_q, acc_y_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     is_mul, is_cor, is_div, start, unit_done, fin_ok;
  logic signed [PROD_W-1:0] mres, head_sh;
  logic [31:0]              mag0, mag1;
  logic signed [31:0]       dist_c, head_c, mx_c, my_c, dx_c;
  logic signed [32:0]       dt_c, ratio_c;
  logic                     dt_nz, rneg;
  logic [COR_W-1:0]         hs_mag;
  logic [DEN_W-1:0]         dt_mag;
  logic [32:0]              qc;
  logic signed [41:0]       rsh_m, nx_c, ny_c;
  logic signed [POS_W-1:0]  acc_x_c, acc_y_c;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [POS_W-1:0] sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) begin
      return 48'sh7fff_ffff_ffff;
    end else if (v < -50'sd140737488355328) begin
      return 48'sh8000_0000_0000;
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

  // Q30 product back to integer, rounding half up
  function automatic logic signed [41:0] rshr30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + 72'sd536870912) >>> 30;
    return t[41:0];
  endfunction

  // magnitude product to Q16.16, rounding half away from zero
  function automatic logic signed [31:0] to_dist(input logic [63:0] p, input logic neg);
    logic [63:0]        t;
    logic signed [49:0] v;
    t = p + 64'd32768;
    v = $signed({2'b00, t[63:16]});
    if (neg) begin
      v = -v;
    end
    return sat32(v);
  endfunction

  // sequencer control
  assign is_mul    = state_q inside {S_BACK, S_SIDE, S_HEAD, S_TDT, S_RX, S_OX, S_RY, S_OY,
                                     S_TL, S_P1, S_P2, S_P3, S_P4};
  assign is_cor    = state_q inside {S_CORD, S_CORL};
  assign is_div    = (state_q == S_DIV);
  assign start     = (is_mul || is_cor || is_div) && !issued_q;
  assign unit_done = mul_rsp.done || cor_rsp.done || div_rsp.done;
  assign fin_ok    = !out_valid_q || !out_stall_i;
  assign mres      = mul_rsp.prod;

  always_comb begin
    issued_d = issued_q;
    if (start) begin
      issued_d = 1'b1;
    end else if (unit_done) begin
      issued_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_BACK;
      S_BACK: if (unit_done) state_d = S_SIDE;
      S_SIDE: if (unit_done) state_d = S_HEAD;
      S_HEAD: if (unit_done) state_d = S_CALC;
      S_CALC: state_d = dt_nz ? S_TDT : S_TL;
      S_TDT:  if (unit_done) state_d = S_CORD;
      S_CORD: if (unit_done) state_d = S_DIV;
      S_DIV:  if (unit_done) state_d = S_RX;
      S_RX:   if (unit_done) state_d = S_OX;
      S_OX:   if (unit_done) state_d = S_RY;
      S_RY:   if (unit_done) state_d = S_OY;
      S_OY:   if (unit_done) state_d = S_TL;
      S_TL:   if (unit_done) state_d = S_CORL;
      S_CORL: if (unit_done) state_d = S_P1;
      S_P1:   if (unit_done) state_d = S_P2;
      S_P2:   if (unit_done) state_d = S_P3;
      S_P3:   if (unit_done) state_d = S_P4;
      S_P4:   if (unit_done) state_d = S_FIN;
      S_FIN:  if (fin_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier operand select
  assign mag0 = in_q.back_wheel_angle[31] ? (32'd0 - unsigned'(in_q.back_wheel_angle))
                                          : unsigned'(in_q.back_wheel_angle);
  assign mag1 = in_q.side_wheel_angle[31] ? (32'd0 - unsigned'(in_q.side_wheel_angle))
                                          : unsigned'(in_q.side_wheel_angle);

  always_comb begin
    mul_req.start = start && is_mul;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (state_q)
      S_BACK: begin
        mul_req.a = {4'b0, mag0};
        mul_req.b = {4'b0, ws_q};
      end
      S_SIDE: begin
        mul_req.a = {4'b0, mag1};
        mul_req.b = {4'b0, ws_q};
      end
      S_HEAD: begin
        mul_req.a = MUL_W'(in_q.gyro_rotation);
        mul_req.b = DEG_TO_RAD_C;
      end
      S_TDT: begin
        mul_req.a = MUL_W'(dt_q);
        mul_req.b = INV_TWO_PI_C;
      end
      S_RX: begin
        mul_req.a = MUL_W'(ratio_q);
        mul_req.b = MUL_W'(mx_q);
      end
      S_OX: begin
        mul_req.a = MUL_W'(ps_q) <<< 1;
        mul_req.b = MUL_W'(bo_q);
      end
      S_RY: begin
        mul_req.a = MUL_W'(ratio_q);
        mul_req.b = MUL_W'(my_q);
      end
      S_OY: begin
        mul_req.a = MUL_W'(ps_q) <<< 1;
        mul_req.b = MUL_W'(so_q);
      end
      S_TL: begin
        mul_req.a = MUL_W'(last_head_q);
        mul_req.b = INV_TWO_PI_C;
      end
      S_P1: begin
        mul_req.a = MUL_W'(pc_q);
        mul_req.b = MUL_W'(dx_q);
      end
      S_P2: begin
        mul_req.a = MUL_W'(ps_q);
        mul_req.b = MUL_W'(dy_q);
      end
      S_P3: begin
        mul_req.a = MUL_W'(pc_q);
        mul_req.b = MUL_W'(dy_q);
      end
      S_P4: begin
        mul_req.a = MUL_W'(ps_q);
        mul_req.b = MUL_W'(dx_q);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // CORDIC and divider requests
  assign hs_mag = ps_q[COR_W-1] ? ({COR_W{1'b0}} - unsigned'(ps_q)) : unsigned'(ps_q);
  assign dt_mag = dt_q[32] ? (33'd0 - unsigned'(dt_q)) : unsigned'(dt_q);

  assign cor_req.start = start && is_cor;
  assign cor_req.turns = turns_q;
  assign div_req.start = start && is_div;
  assign div_req.num   = {hs_mag, 17'd0};
  assign div_req.den   = dt_mag;

  // result shaping
  assign dist_c  = to_dist(mres[63:0], (state_q == S_SIDE) ? !in_q.side_wheel_angle[31]
                                                           : in_q.back_wheel_angle[31]);
  assign head_sh = (mres + 72'sd8388608) >>> 24;
  assign head_c  = sat32(head_sh[49:0]);
  assign mx_c    = sat32(50'(back_q) - 50'(last_back_q));
  assign my_c    = sat32(50'(side_q) - 50'(last_side_q));
  assign dt_c    = 33'(head_q) - 33'(last_head_q);
  assign dt_nz   = (dt_c != '0);

  // arc factor clamps to a magnitude of 2^31 either way
  assign rneg    = ps_q[COR_W-1] ^ dt_q[32];
  assign qc      = (div_rsp.quo > 51'd2147483648) ? 33'h0_8000_0000 : div_rsp.quo[32:0];
  assign ratio_c = rneg ? (33'd0 - qc) : qc;

  assign rsh_m   = rshr30(mres);
  assign dx_c    = sat32(50'(r1_q) + 50'(rsh_m));
  assign nx_c    = rshr30(p1_q + mres);
  assign ny_c    = rshr30(p1_q - mres);
  assign acc_x_c = sat48(50'(acc_x_q) + 50'(nx_q));
  assign acc_y_c = sat48(50'(acc_y_q) + 50'(ny_q));

  // control, registers and state that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ws_q        <= WHEEL_SCALE_RST;
      bo_q        <= BACK_OFFSET_RST;
      so_q        <= SIDE_OFFSET_RST;
      last_back_q <= '0;
      last_side_q <= '0;
      last_head_q <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WHEEL_SCALE: ws_q <= cfg_data_i;
          CFG_BACK_OFFSET: bo_q <= cfg_data_i;
          CFG_SIDE_OFFSET: so_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_FIN && fin_ok) begin
        out_valid_q <= 1'b1;
        acc_x_q     <= acc_x_c;
        acc_y_q     <= acc_y_c;
        last_back_q <= back_q;
        last_side_q <= side_q;
        last_head_q <= head_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the sequence
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (unit_done) begin
      case (state_q)
        S_BACK: back_q  <= dist_c;
        S_SIDE: side_q  <= dist_c;
        S_HEAD: head_q  <= head_c;
        S_TDT:  turns_q <= mres[48:17];
        S_DIV:  ratio_q <= ratio_c;
        S_RX:   r1_q    <= rsh_m;
        S_OX:   dx_q    <= dx_c;
        S_RY:   r1_q    <= rsh_m;
        S_OY:   dy_q    <= dx_c;
        S_TL:   turns_q <= mres[47:16];
        S_P1:   p1_q    <= mres;
        S_P2:   nx_q    <= nx_c;
        S_P3:   p1_q    <= mres;
        S_P4:   ny_q    <= ny_c;
        S_CORD, S_CORL: begin
          pc_q <= cor_rsp.c;
          ps_q <= cor_rsp.s;
        end
        default: ;
      endcase
    end
    if (state_q == S_CALC) begin
      mx_q <= mx_c;
      my_q <= my_c;
      dt_q <= dt_c;
      if (!dt_nz) begin
        dx_q <= mx_c;
        dy_q <= my_c;
      end
    end
    if (state_q == S_FIN && fin_ok) begin
      out_q.pos_x <= acc_x_c;
      out_q.pos_y <= acc_y_c;
    end
  end

  two_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  two_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  two_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import two_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint INV_TWO_PI_K  = 64'sd683565276;
  localparam longint DEG_TO_RAD_K  = 64'sd74961321;
  localparam longint ROT_GAIN_K    = 64'sd652032874;
  localparam longint POS_MAX       = 64'sd140737488355327;
  localparam longint POS_MIN       = -64'sd140737488355328;
  localparam int     FRAC          = 16;
  localparam int     ROT_STEPS     = 24;
  localparam int     SETTLE_CYCLES = 400;
  localparam int     CYCLE_LIMIT   = 1500000;

  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  tracking_wheel_odometry uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // odometry predictor state
  logic [31:0] scale_m = WHEEL_SCALE_RST;
  longint back_off_m = BACK_OFFSET_RST;
  longint side_off_m = SIDE_OFFSET_RST;
  longint prev_back, prev_side, prev_head, acc_x_m, acc_y_m;

  in_item_t  tick_q [$];
  out_item_t pos_expect_q [$];
  int unsigned cyc = 0;
  int unsigned bad_cnt = 0;
  bit calm;

  assign calm = (cyc >= 30000) && (cyc < 90000);

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // encoder degrees to Q16.16 inches, rounded half away from zero
  function automatic longint wheel_dist(logic signed [31:0] ang, bit flip);
    longint a;
    bit [63:0] mag;
    longint r;
    a = ang;
    mag = 64'(a < 0 ? -a : a) * {32'd0, scale_m};
    r = longint'((mag + 64'd32768) >> 16);
    return clamp32(((a < 0) != flip) ? -r : r);
  endfunction

  // radians to binary angle (one turn = 2^32)
  function automatic logic [31:0] rad_to_binang(longint a, int extra);
    bit [63:0] u;
    u = a * INV_TWO_PI_K;
    return 32'(u >> (FRAC + extra));
  endfunction

  function automatic void rotate_unit(logic [31:0] t, output longint c, output longint s);
    bit half;
    longint x, y, z, nx;
    logic [31:0] q;
    half = ((t + 32'h4000_0000) & 32'h8000_0000) != 0;
    q = half ? t + 32'h8000_0000 : t;
    z = longint'(signed'(q));
    x = ROT_GAIN_K;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_LUT[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_LUT[i];
      end
      x = nx;
    end
    c = half ? -x : x;
    s = half ? -y : y;
  endfunction

  function automatic out_item_t advance_pose(in_item_t it);
    longint back, side, head, mx, my, dt, dx, dy, hc, hs, ratio, pc, ps;
    out_item_t o;
    back = wheel_dist(it.back_wheel_angle, 1'b0);
    side = wheel_dist(it.side_wheel_angle, 1'b1);
    head = clamp32(round_shr(longint'(it.gyro_rotation) * DEG_TO_RAD_K, 40 - FRAC));
    mx = clamp32(back - prev_back);
    my = clamp32(side - prev_side);
    dt = head - prev_head;
    if (dt != 0) begin
      rotate_unit(rad_to_binang(dt, 1), hc, hs);
      ratio = (2 * hs * (longint'(1) <<< FRAC)) / dt;
      ratio = clamp(ratio, -64'sd2147483648, 64'sd2147483648);
      dx = clamp32(round_shr(ratio * mx, 30) + round_shr(2 * hs * back_off_m, 30));
      dy = clamp32(round_shr(ratio * my, 30) + round_shr(2 * hs * side_off_m, 30));
    end else begin
      dx = mx;
      dy = my;
    end
    rotate_unit(rad_to_binang(prev_head, 0), pc, ps);
    acc_x_m = clamp(acc_x_m + round_shr(pc * dx + ps * dy, 30), POS_MIN, POS_MAX);
    acc_y_m = clamp(acc_y_m + round_shr(pc * dy - ps * dx, 30), POS_MIN, POS_MAX);
    prev_back = back;
    prev_side = side;
    prev_head = head;
    o.pos_x = acc_x_m[POS_W-1:0];
    o.pos_y = acc_y_m[POS_W-1:0];
    return o;
  endfunction

  // sender: presents queued ticks, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      prev_back = 0;
      prev_side = 0;
      prev_head = 0;
      acc_x_m = 0;
      acc_y_m = 0;
    end else begin
      if (in_valid && !in_stall)
        pos_expect_q.push_back(advance_pose(in_data));
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_data <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, compare against oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
      if (out_valid && !out_stall) begin
        if (pos_expect_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result x=%0d y=%0d", out_data.pos_x, out_data.pos_y);
        end else begin
          if (out_data !== pos_expect_q[0]) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("pos error: expected x=%0d y=%0d got x=%0d y=%0d",
                       pos_expect_q[0].pos_x, pos_expect_q[0].pos_y,
                       out_data.pos_x, out_data.pos_y);
          end
          void'(pos_expect_q.pop_front());
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tracking_wheel_odometry: mismatch");
      $finish;
    end
  end

  task automatic add_tick(logic [31:0] b, logic [31:0] s, logic [31:0] g);
    in_item_t it;
    it.back_wheel_angle = b;
    it.side_wheel_angle = s;
    it.gyro_rotation = g;
    tick_q.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tick_q.size() != 0 || in_valid || pos_expect_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WHEEL_SCALE: scale_m = val;
      CFG_BACK_OFFSET: back_off_m = longint'(signed'(val));
      CFG_SIDE_OFFSET: side_off_m = longint'(signed'(val));
      default: ;
    endcase
  endtask

  // mostly smooth motion runs, some raw noise
  task automatic random_ticks(int n);
    logic [31:0] b, s, g;
    int len;
    b = $urandom;
    s = $urandom;
    g = $urandom;
    while (n > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        add_tick($urandom, $urandom, $urandom);
        n--;
      end else begin
        len = $urandom_range(4, 20);
        if ($urandom_range(0, 3) == 0) begin
          b = $urandom;
          s = $urandom;
          g = $urandom;
        end
        for (int k = 0; k < len && n > 0; k++) begin
          b += $urandom_range(0, 8000) - 4000;
          s += $urandom_range(0, 8000) - 4000;
          if ($urandom_range(0, 2) != 0)
            g += $urandom_range(0, 6000) - 3000;
          add_tick(b, s, g);
          n--;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first step from zero history, extremes, still heading, turns
    add_tick(32'd0, 32'd0, 32'd0);
    add_tick(32'd2560, 32'd0, 32'd0);
    add_tick(32'd2560, 32'd1280, 32'd0);
    add_tick(32'd5120, 32'd1280, 32'd2304);
    add_tick(32'd5120, 32'd1280, 32'd2304);
    add_tick(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_tick(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_tick(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_tick(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_tick(32'd0, 32'd0, 32'd46080);
    add_tick(32'd0, 32'd0, 32'hfffe_9800);
    add_tick(32'd1, 32'hffff_ffff, 32'd1);
    add_tick(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    add_tick(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    random_ticks(110);
    drain();

    // random registers
    write_reg(CFG_WHEEL_SCALE, $urandom_range(0, 4000000));
    write_reg(CFG_BACK_OFFSET, $urandom);
    write_reg(CFG_SIDE_OFFSET, $urandom);
    random_ticks(110);
    drain();

    // extremes: largest scale, most negative offsets, drives saturation
    write_reg(CFG_WHEEL_SCALE, 32'hffff_ffff);
    write_reg(CFG_BACK_OFFSET, 32'h8000_0000);
    write_reg(CFG_SIDE_OFFSET, 32'h8000_0000);
    add_tick(32'h7fff_ffff, 32'h8000_0000, 32'd0);
    add_tick(32'h8000_0000, 32'h7fff_ffff, 32'd0);
    add_tick(32'h7fff_ffff, 32'h8000_0000, 32'd0);
    random_ticks(110);
    drain();

    // zero scale, largest offsets; spare index must be ignored
    write_reg(CFG_WHEEL_SCALE, 32'd0);
    write_reg(CFG_BACK_OFFSET, 32'h7fff_ffff);
    write_reg(CFG_SIDE_OFFSET, 32'h7fff_ffff);
    write_reg(CFG_SPARE, $urandom);
    random_ticks(60);
    drain();
    write_reg(CFG_WHEEL_SCALE, WHEEL_SCALE_RST);
    write_reg(CFG_BACK_OFFSET, BACK_OFFSET_RST);
    write_reg(CFG_SPARE, $urandom);
    random_ticks(60);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_cnt == 0 && pos_expect_q.size() == 0) begin
      $display("tracking_wheel_odometry: match");
    end else begin
      $display("tracking_wheel_odometry: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
